/* rtl/digitizer_event_record_parser_core_macros.svh */
// Assertion macros shared by the parser RTL.
`ifndef DIGITIZER_EVENT_RECORD_PARSER_CORE_MACROS_SVH
`define DIGITIZER_EVENT_RECORD_PARSER_CORE_MACROS_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define DERP_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("parser assertion failed");

// Next-cycle implication, checked on every clock edge outside reset.
`define DERP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("parser assertion failed");

`endif

/* rtl/derp_pkg.sv */
// Types, codes and constants of the digitizer event record parser.
package derp_pkg;

	localparam int FRACTION_BITS = 16;
	// Quotient width of the constant-fraction ratio: numerator magnitude plus fraction.
	localparam int QUO_W = 16 + FRACTION_BITS;

	localparam logic [15:0] FLAG_MASK  = 16'hfc00;
	localparam logic [15:0] FINE_MASK  = 16'h03ff;
	localparam logic [15:0] CFD_THRESH = 16'd8192;

	localparam logic [1:0] TYPE_PSD  = 2'd1;
	localparam logic [1:0] TYPE_WAVE = 2'd2;

	localparam logic [15:0] SELW_BASE  = 16'd0;
	localparam logic [15:0] SELW_FLAGS = 16'd2;
	localparam logic [15:0] SELW_CFD   = 16'd5;

	typedef enum logic [4:0] {
		PH_SIZE_LO, PH_SIZE_HI, PH_TYPE_LO, PH_TYPE_HI, PH_CH_LO, PH_CH_HI,
		PH_TAG_LO, PH_TAG_HI, PH_SEL, PH_EX1, PH_EX2, PH_SQ, PH_LQ,
		PH_SKIP1, PH_SKIP2, PH_CNT_LO, PH_CNT_HI, PH_SAMP
	} phase_t;

	typedef enum logic [1:0] {
		KIND_SAMPLE, KIND_SUMMARY, KIND_BAD_TYPE, KIND_BAD_SEL
	} kind_t;

	typedef enum logic [1:0] {
		SEL_BASE, SEL_FLAGS, SEL_CFD
	} sel_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

/* rtl/derp_div.sv */
// Bit-serial signed ratio unit for the constant-fraction fine time.
module derp_div (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [15:0]         neg,
	input  logic [15:0]         pos,
	output derp_pkg::div_stat_t stat,
	output logic [31:0]         result
);
	import derp_pkg::*;

	localparam int CW = $clog2(QUO_W + 1);

	logic              busy_q;
	logic              done_q;
	logic              sign_q;
	logic [CW-1:0]     cnt_q;
	logic [15:0]       den_q;
	logic [15:0]       rem_q;
	logic [QUO_W-1:0]  dvd_q;
	logic [31:0]       res_q;

	logic signed [17:0] num_c;
	logic signed [17:0] den_c;
	logic signed [17:0] an_c;
	logic signed [17:0] ad_c;
	logic [16:0]        trial_c;
	logic               fits_c;
	logic [63:0]        mag_c;

	always_comb begin
		num_c   = $signed({2'b00, CFD_THRESH}) - $signed({2'b00, neg});
		den_c   = $signed({2'b00, pos}) - $signed({2'b00, neg});
		an_c    = (num_c < 0) ? -num_c : num_c;
		ad_c    = (den_c < 0) ? -den_c : den_c;
		trial_c = {rem_q, dvd_q[QUO_W-1]};
		fits_c  = trial_c >= {1'b0, den_q};
		mag_c   = 64'(dvd_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				if (den_c == 0) begin
					// A zero divisor saturates on the sign of the numerator alone.
					done_q <= 1'b1;
					res_q  <= (num_c < 0) ? 32'h80000000 : 32'h7fffffff;
				end else begin
					busy_q <= 1'b1;
					cnt_q  <= CW'(QUO_W);
					sign_q <= (num_c < 0) != (den_c < 0);
					den_q  <= ad_c[15:0];
					rem_q  <= '0;
					dvd_q  <= {an_c[15:0], {FRACTION_BITS{1'b0}}};
				end
			end else if (busy_q && cnt_q != '0) begin
				// One restoring step: quotient bits shift in where dividend bits leave.
				cnt_q <= cnt_q - 1'b1;
				rem_q <= fits_c ? 16'(trial_c - {1'b0, den_q}) : trial_c[15:0];
				dvd_q <= {dvd_q[QUO_W-2:0], fits_c};
			end else if (busy_q) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
				if (!sign_q)
					res_q <= (mag_c > 64'h7fffffff) ? 32'h7fffffff : mag_c[31:0];
				else
					res_q <= (mag_c > 64'h80000000) ? 32'h80000000 : 32'd0 - mag_c[31:0];
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign result    = res_q;

endmodule

/* rtl/digitizer_event_record_parser_core.sv */
// Top level of the digitizer event record parser.
//
//  channel   signals                          beat
//  input     in_valid, in_ready, word         one 16-bit stream word
//  output    out_valid, out_ready, kind ...   one summary, sample or error result
//
// Each stream word is taken on a beat with in_valid and in_ready high. The second
// extras word of a selector-5 record starts the bit-serial ratio unit, which holds
// input off while it is busy; a zero divisor never sets it busy.
// Reset clears the record state, the output valid flag and the ratio unit's busy, done and step count.
// A result waiting in the output register holds input off while out_ready is low.
module digitizer_event_record_parser_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [15:0]        word,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         kind,
	output logic [1:0]         event_type,
	output logic [2:0]         channel,
	output logic [31:0]        time_tag,
	output logic [15:0]        ext_time,
	output logic [15:0]        short_charge,
	output logic [15:0]        long_charge,
	output logic [13:0]        baseline,
	output logic [15:0]        flags,
	output logic signed [31:0] fine_time,
	output logic [15:0]        sample,
	output logic               last
);
	import derp_pkg::*;

	`include "digitizer_event_record_parser_core_macros.svh"

	phase_t      phase_q, phase_d;
	logic        halted_q;
	logic [15:0] low_q;
	logic [1:0]  type_q;
	sel_t        sel_q;
	logic [2:0]  channel_q;
	logic [31:0] tag_q;
	logic [15:0] ext_q;
	logic [15:0] short_q;
	logic [15:0] long_q;
	logic [13:0] base_q;
	logic [15:0] flag_q;
	logic [31:0] fine_q;
	logic [15:0] neg_q;
	logic [31:0] left_q;

	logic        out_valid_q;
	kind_t       kind_q;
	logic [1:0]  etype_q;
	logic [2:0]  ochan_q;
	logic [31:0] otag_q;
	logic [15:0] oext_q;
	logic [15:0] oshort_q;
	logic [15:0] olong_q;
	logic [13:0] obase_q;
	logic [15:0] oflag_q;
	logic [31:0] ofine_q;
	logic [15:0] osample_q;
	logic        olast_q;

	logic                    acc;
	logic                    emit;
	kind_t                   emit_kind;
	logic                    emit_last;
	logic                    emit_sample;
	logic                    halt_set;
	logic                    div_start;
	div_stat_t               div_stat;
	logic [31:0]             div_result;
	logic [31:0]             tag_c;
	logic [31:0]             count_c;
	logic [9+FRACTION_BITS:0] fine2_c;

	assign in_ready = !div_stat.busy && (!out_valid_q || out_ready);
	assign acc      = in_valid && in_ready;
	assign tag_c    = {word, low_q};
	assign count_c  = {word, low_q};
	assign fine2_c  = {word[9:0] & FINE_MASK[9:0], {FRACTION_BITS{1'b0}}};

	derp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.neg    (neg_q),
		.pos    (word),
		.stat   (div_stat),
		.result (div_result)
	);

	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			PH_SIZE_LO: phase_d = PH_SIZE_HI;
			PH_SIZE_HI: phase_d = PH_TYPE_LO;
			PH_TYPE_LO: phase_d = PH_TYPE_HI;
			PH_TYPE_HI: phase_d = PH_CH_LO;
			PH_CH_LO:   phase_d = PH_CH_HI;
			PH_CH_HI:   phase_d = PH_TAG_LO;
			PH_TAG_LO:  phase_d = PH_TAG_HI;
			PH_TAG_HI:  phase_d = (type_q == TYPE_WAVE) ? PH_CNT_LO : PH_SEL;
			PH_SEL:     phase_d = PH_EX1;
			PH_EX1:     phase_d = PH_EX2;
			PH_EX2:     phase_d = PH_SQ;
			PH_SQ:      phase_d = PH_LQ;
			PH_LQ:      phase_d = PH_SKIP1;
			PH_SKIP1:   phase_d = PH_SKIP2;
			PH_SKIP2:   phase_d = PH_CNT_LO;
			PH_CNT_LO:  phase_d = PH_CNT_HI;
			PH_CNT_HI:  phase_d = (count_c == '0) ? PH_SIZE_LO : PH_SAMP;
			PH_SAMP:    phase_d = (left_q == 32'd1) ? PH_SIZE_LO : PH_SAMP;
			default:    phase_d = PH_SIZE_LO;
		endcase
	end

	always_comb begin
		emit        = 1'b0;
		emit_kind   = KIND_SAMPLE;
		emit_last   = 1'b0;
		emit_sample = 1'b0;
		halt_set    = 1'b0;
		div_start   = 1'b0;
		unique case (phase_q)
			PH_TAG_HI: begin
				if (type_q != TYPE_PSD && type_q != TYPE_WAVE) begin
					emit      = 1'b1;
					emit_kind = KIND_BAD_TYPE;
					emit_last = 1'b1;
					halt_set  = 1'b1;
				end
			end
			PH_SEL: begin
				if (word != SELW_BASE && word != SELW_FLAGS && word != SELW_CFD) begin
					emit      = 1'b1;
					emit_kind = KIND_BAD_SEL;
					emit_last = 1'b1;
					halt_set  = 1'b1;
				end
			end
			PH_EX2: div_start = (sel_q == SEL_CFD);
			PH_CNT_HI: begin
				emit      = 1'b1;
				emit_kind = KIND_SUMMARY;
				emit_last = (count_c == '0);
			end
			PH_SAMP: begin
				emit        = 1'b1;
				emit_kind   = KIND_SAMPLE;
				emit_last   = (left_q == 32'd1);
				emit_sample = 1'b1;
			end
			default: ;
		endcase
		// Once halted every beat is swallowed.
		if (halted_q || !acc) begin
			emit      = 1'b0;
			halt_set  = 1'b0;
			div_start = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_SIZE_LO;
			halted_q  <= 1'b0;
			low_q     <= '0;
			type_q    <= '0;
			sel_q     <= SEL_BASE;
			channel_q <= '0;
			tag_q     <= '0;
			ext_q     <= '0;
			short_q   <= '0;
			long_q    <= '0;
			base_q    <= '0;
			flag_q    <= '0;
			fine_q    <= '0;
			neg_q     <= '0;
			left_q    <= '0;
		end else begin
			if (div_stat.done)
				fine_q <= div_result;
			if (acc && !halted_q) begin
				phase_q <= phase_d;
				if (halt_set)
					halted_q <= 1'b1;
				unique case (phase_q)
					PH_TYPE_LO, PH_TAG_LO, PH_CNT_LO: low_q <= word;
					PH_TYPE_HI: type_q <= (word == '0 &&
						(low_q == 16'(TYPE_PSD) || low_q == 16'(TYPE_WAVE))) ? low_q[1:0] : 2'd0;
					PH_CH_LO:   channel_q <= word[2:0];
					PH_TAG_HI:  tag_q <= tag_c;
					PH_SEL: begin
						if (word == SELW_BASE)
							sel_q <= SEL_BASE;
						else if (word == SELW_FLAGS)
							sel_q <= SEL_FLAGS;
						else
							sel_q <= SEL_CFD;
					end
					PH_EX1: begin
						unique case (sel_q)
							SEL_BASE: base_q <= word[15:2];
							SEL_FLAGS: begin
								flag_q <= word & FLAG_MASK;
								fine_q <= (64'(fine2_c) > 64'h7fffffff) ? 32'h7fffffff
									: 32'(fine2_c);
							end
							default: neg_q <= word;
						endcase
					end
					PH_EX2:     if (sel_q != SEL_CFD) ext_q <= word;
					PH_SQ:      short_q <= word;
					PH_LQ:      long_q <= word;
					PH_CNT_HI:  left_q <= count_c;
					PH_SAMP:    left_q <= left_q - 32'd1;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// A bad-type error carries the time tag that arrives on the same beat.
	always_ff @(posedge clk) begin
		if (emit) begin
			kind_q    <= emit_kind;
			etype_q   <= type_q;
			ochan_q   <= channel_q;
			otag_q    <= (phase_q == PH_TAG_HI) ? tag_c : tag_q;
			oext_q    <= ext_q;
			oshort_q  <= short_q;
			olong_q   <= long_q;
			obase_q   <= base_q;
			oflag_q   <= flag_q;
			ofine_q   <= fine_q;
			osample_q <= emit_sample ? word : 16'd0;
			olast_q   <= emit_last;
		end
	end

	assign out_valid    = out_valid_q;
	assign kind         = kind_q;
	assign event_type   = etype_q;
	assign channel      = ochan_q;
	assign time_tag     = otag_q;
	assign ext_time     = oext_q;
	assign short_charge = oshort_q;
	assign long_charge  = olong_q;
	assign baseline     = obase_q;
	assign flags        = oflag_q;
	assign fine_time    = $signed(ofine_q);
	assign sample       = osample_q;
	assign last         = olast_q;

	`DERP_ASSERT_NEXT(a_halt_silent, halted_q && !out_valid_q, !out_valid_q)
	`DERP_ASSERT_IMPL(a_div_done_phase, div_stat.done, phase_q == PH_SQ && !halted_q)
	`DERP_ASSERT_IMPL(a_error_last,
		out_valid_q && (kind_q == KIND_BAD_TYPE || kind_q == KIND_BAD_SEL), olast_q)

endmodule
